@@ hw/rtl/u8tsc_pkg.sv @@
package u8tsc_pkg;

	// Verdict codes, in order of test priority after the empty check
	typedef enum logic [2:0] {
		ST_TRUSTED      = 3'd0,
		ST_NO_TEXT      = 3'd1,
		ST_REPLACEMENTS = 3'd2,
		ST_CONTROL      = 3'd3,
		ST_COUNT        = 3'd4
	} status_t;

	localparam int S_TDATA_W = 48;
	localparam int M_TDATA_W = 56;

	// Result tdata layout, low bit first
	localparam int M_ACCEPT_BIT   = 0;
	localparam int M_STATUS_LSB   = 1;
	localparam int M_STATUS_W     = 3;
	localparam int M_CHAR_LSB     = 4;
	localparam int M_REPL_LSB     = 20;
	localparam int M_CTRL_LSB     = 36;
	localparam int M_COUNT_W      = 16;
	localparam int M_PAD_LSB      = 52;

endpackage

@@ hw/rtl/utf8_text_sanity_checker_top.sv @@
// Channel  Fields, low bit first                                     Transfer
// s_axis   tdata: data_byte[7:0] box_width_q4[25:8]                   tvalid & tready
//          box_height_q4[43:26] zero[47:44]; tuser: carries_byte;
//          tlast: last
// m_axis   tdata: accept[0] status[3:1] char_count[19:4]               tvalid & tready
//          replacement_count[35:20] control_count[51:36] zero[55:52]
//
// One byte per cycle while s_axis_tready is high. The last byte of a string
// passes through the input register, decode and count update, verdict and
// output register before its result appears on m_axis.
// arst_n clears the counters, the held byte count and all valid flags.
// A waiting result holds only the stages behind it; bytes keep flowing until
// a third tlast item reaches the decode stage while both later stages are full.
module utf8_text_sanity_checker_top
	import u8tsc_pkg::*;
#(
	parameter int COUNT_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_axis_tvalid,
	output logic                 s_axis_tready,
	input  logic [S_TDATA_W-1:0] s_axis_tdata,  // data_byte, box_width_q4, box_height_q4
	input  logic                 s_axis_tuser,  // carries_byte
	input  logic                 s_axis_tlast,
	output logic                 m_axis_tvalid,
	input  logic                 m_axis_tready,
	output logic [M_TDATA_W-1:0] m_axis_tdata   // accept, status, char, repl, ctrl counts
);

	localparam int CW  = COUNT_WIDTH;
	localparam int VW  = COUNT_WIDTH + 10;
	localparam int CPW = 21;

	localparam logic [CPW-1:0] CP_REPLACEMENT = 21'h00FFFD;
	localparam logic [CPW-1:0] CP_SPACE       = 21'h000020;
	localparam logic [CPW-1:0] CP_TAB         = 21'h000009;
	localparam logic [CPW-1:0] CP_LF          = 21'h00000A;
	localparam logic [CPW-1:0] CP_CR          = 21'h00000D;

	function automatic logic [2:0] lead_len(input logic [7:0] c);
		logic [2:0] len;
		if (!c[7]) begin
			len = 3'd1;
		end else if (c[7:5] == 3'b110) begin
			len = 3'd2;
		end else if (c[7:4] == 4'b1110) begin
			len = 3'd3;
		end else if (c[7:3] == 5'b11110) begin
			len = 3'd4;
		end else begin
			len = 3'd1;
		end
		return len;
	endfunction

	// Lone byte: ASCII passes, anything else decodes as zero
	function automatic logic [CPW-1:0] single_cp(input logic [7:0] c);
		return c[7] ? '0 : {13'd0, c};
	endfunction

	function automatic logic is_ctrl(input logic [CPW-1:0] cp);
		return (cp < CP_SPACE) && (cp != CP_TAB) && (cp != CP_LF) && (cp != CP_CR);
	endfunction

	function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] v, input logic [2:0] d);
		logic [CW:0] sum;
		sum = {1'b0, v} + (CW+1)'(d);
		return sum[CW] ? '1 : sum[CW-1:0];
	endfunction

	// Input register
	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        carries_s1;
	logic        last_s1;
	logic [17:0] width_s1;
	logic [17:0] height_s1;

	// Decoder state
	logic [7:0]    held_q [3];
	logic [1:0]    held_cnt_q;
	logic [CW-1:0] point_cnt_q;
	logic [CW-1:0] fffd_cnt_q;
	logic [CW-1:0] ctrl_cnt_q;

	// Verdict stage
	logic          valid_s2;
	logic [CW-1:0] point_s2;
	logic [CW-1:0] fffd_s2;
	logic [CW-1:0] ctrl_s2;
	logic [17:0]   width_s2;
	logic [17:0]   height_s2;

	// Output register
	logic                 out_valid_q;
	logic                 accept_q;
	status_t              status_q;
	logic [M_COUNT_W-1:0] char_q;
	logic [M_COUNT_W-1:0] repl_q;
	logic [M_COUNT_W-1:0] ctrl_q;

	logic out_free, s2_free, s1_go;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s2_free       = !valid_s2 || out_free;
	assign s1_go         = valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !valid_s1 || s1_go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			byte_s1    <= s_axis_tdata[7:0];
			width_s1   <= s_axis_tdata[25:8];
			height_s1  <= s_axis_tdata[43:26];
			carries_s1 <= s_axis_tuser;
			last_s1    <= s_axis_tlast;
		end
	end

	// Byte intake, then the tail flush on the last byte
	logic [7:0]     held_n [3];
	logic [1:0]     held_cnt_n;
	logic [2:0]     need;
	logic           tally_vld [4];
	logic [CPW-1:0] tally_cp  [4];
	logic           h1_pair;
	logic [2:0]     point_inc, fffd_inc, ctrl_inc;

	always_comb begin
		held_n     = held_q;
		held_cnt_n = held_cnt_q;
		need       = lead_len(held_q[0]);
		tally_vld[0] = 1'b0;
		tally_cp[0]  = '0;
		if (carries_s1) begin
			if (held_cnt_q == 2'd0) begin
				if (lead_len(byte_s1) == 3'd1) begin
					tally_vld[0] = 1'b1;
					tally_cp[0]  = single_cp(byte_s1);
				end else begin
					held_n[0]  = byte_s1;
					held_cnt_n = 2'd1;
				end
			end else if ({1'b0, held_cnt_q} + 3'd1 >= need) begin
				tally_vld[0] = 1'b1;
				held_cnt_n   = 2'd0;
				case (need)
					3'd2: tally_cp[0] = {10'd0, held_q[0][4:0], byte_s1[5:0]};
					3'd3: tally_cp[0] = {5'd0, held_q[0][3:0], held_q[1][5:0], byte_s1[5:0]};
					default: tally_cp[0] = {held_q[0][2:0], held_q[1][5:0], held_q[2][5:0],
						byte_s1[5:0]};
				endcase
			end else begin
				held_n[held_cnt_q] = byte_s1;
				held_cnt_n         = held_cnt_q + 2'd1;
			end
		end

		// The first held byte is an unfinished lead and always decodes as zero;
		// only a two-byte lead in the middle slot can still complete.
		h1_pair      = (held_cnt_n == 2'd3) && (held_n[1][7:5] == 3'b110);
		tally_vld[1] = last_s1 && (held_cnt_n != 2'd0);
		tally_cp[1]  = '0;
		tally_vld[2] = last_s1 && held_cnt_n[1];
		tally_cp[2]  = h1_pair ? {10'd0, held_n[1][4:0], held_n[2][5:0]}
			: single_cp(held_n[1]);
		tally_vld[3] = last_s1 && (held_cnt_n == 2'd3) && !h1_pair;
		tally_cp[3]  = single_cp(held_n[2]);

		point_inc = '0;
		fffd_inc  = '0;
		ctrl_inc  = '0;
		for (int i = 0; i < 4; i++) begin
			point_inc = point_inc + 3'(tally_vld[i]);
			fffd_inc  = fffd_inc + 3'(tally_vld[i] && (tally_cp[i] == CP_REPLACEMENT));
			ctrl_inc  = ctrl_inc + 3'(tally_vld[i] && is_ctrl(tally_cp[i]));
		end
	end

	logic [CW-1:0] point_nx, fffd_nx, ctrl_nx;

	assign point_nx = sat_add(point_cnt_q, point_inc);
	assign fffd_nx  = sat_add(fffd_cnt_q, fffd_inc);
	assign ctrl_nx  = sat_add(ctrl_cnt_q, ctrl_inc);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_cnt_q  <= '0;
			point_cnt_q <= '0;
			fffd_cnt_q  <= '0;
			ctrl_cnt_q  <= '0;
		end else if (s1_go) begin
			if (last_s1) begin
				held_cnt_q  <= '0;
				point_cnt_q <= '0;
				fffd_cnt_q  <= '0;
				ctrl_cnt_q  <= '0;
			end else begin
				held_cnt_q  <= held_cnt_n;
				point_cnt_q <= point_nx;
				fffd_cnt_q  <= fffd_nx;
				ctrl_cnt_q  <= ctrl_nx;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go) begin
			held_q <= held_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_free && s1_go && last_s1) begin
			point_s2  <= point_nx;
			fffd_s2   <= fffd_nx;
			ctrl_s2   <= ctrl_nx;
			width_s2  <= width_s1;
			height_s2 <= height_s1;
		end
	end

	// Verdict: constant multiples built from shifts
	logic [VW-1:0] n_w, f20, c10, n960, n16, w_w;
	status_t       status_nx;

	always_comb begin
		n_w  = VW'(point_s2);
		f20  = (VW'(fffd_s2) << 4) + (VW'(fffd_s2) << 2);
		c10  = (VW'(ctrl_s2) << 3) + (VW'(ctrl_s2) << 1);
		n960 = (n_w << 10) - (n_w << 6);
		n16  = n_w << 4;
		w_w  = VW'(width_s2);
		if (point_s2 == '0) begin
			status_nx = ST_NO_TEXT;
		end else if (f20 > n_w) begin
			status_nx = ST_REPLACEMENTS;
		end else if (c10 > n_w) begin
			status_nx = ST_CONTROL;
		end else if ((width_s2 != '0) && (height_s2 != '0) && ((n960 < w_w) || (n16 > w_w)))
			begin
			status_nx = ST_COUNT;
		end else begin
			status_nx = ST_TRUSTED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && valid_s2) begin
			accept_q <= (status_nx == ST_TRUSTED);
			status_q <= status_nx;
			char_q   <= M_COUNT_W'(point_s2);
			repl_q   <= M_COUNT_W'(fffd_s2);
			ctrl_q   <= M_COUNT_W'(ctrl_s2);
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {(M_TDATA_W-M_PAD_LSB)'(0), ctrl_q, repl_q, char_q, status_q, accept_q};

endmodule

@@ hw/rtl/u8tsc_checker.sv @@
module u8tsc_checker
	import u8tsc_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 m_axis_tvalid,
	input logic                 m_axis_tready,
	input logic [M_TDATA_W-1:0] m_axis_tdata
);

	logic [M_STATUS_W-1:0] status;
	logic                  zero_counts;

	assign status      = m_axis_tdata[M_STATUS_LSB +: M_STATUS_W];
	assign zero_counts = (m_axis_tdata[M_CHAR_LSB +: M_COUNT_W] == '0)
		&& (m_axis_tdata[M_REPL_LSB +: M_COUNT_W] == '0)
		&& (m_axis_tdata[M_CTRL_LSB +: M_COUNT_W] == '0);

	// accept flag must agree with the verdict code
	a_accept_match: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_ACCEPT_BIT] == (status == ST_TRUSTED)))
		else $error("accept flag disagrees with status");

	// a no-text verdict carries all-zero counts
	a_empty_counts: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (status == ST_NO_TEXT) |-> zero_counts)
		else $error("no-text verdict with nonzero counts");

	// result padding is always zero
	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[M_TDATA_W-1:M_PAD_LSB] == '0))
		else $error("result padding not zero");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("stalled result changed");

endmodule

bind utf8_text_sanity_checker_top u8tsc_checker u_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata)
);

@@ sim/utf8_text_sanity_checker_top_test.sv @@
module utf8_text_sanity_checker_top_test;
	import u8tsc_pkg::*;

	localparam int          CNT_W       = 16;
	localparam int unsigned CNT_MAX     = (1 << CNT_W) - 1;
	localparam int          HOLD_CYCLES = 400;
	localparam int          TAIL_CYCLES = 20;
	localparam logic [17:0] BOX_MAX     = 18'h3FFFF;

	localparam int unsigned CP_TAB         = 32'h09;
	localparam int unsigned CP_LF          = 32'h0A;
	localparam int unsigned CP_CR          = 32'h0D;
	localparam int unsigned CP_SPACE       = 32'h20;
	localparam int unsigned CP_REPLACEMENT = 32'hFFFD;

	typedef logic [7:0] text_q_t[$];

	typedef struct {
		logic        accept;
		status_t     status;
		logic [15:0] chars;
		logic [15:0] repl;
		logic [15:0] ctrl;
	} verdict_t;

	logic                 clk;
	logic                 arst_n        = 1'b0;
	logic                 s_axis_tvalid = 1'b0;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
	logic                 s_axis_tuser  = 1'b0;
	logic                 s_axis_tlast  = 1'b0;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_axis_tdata;

	utf8_text_sanity_checker_top #(.COUNT_WIDTH(CNT_W)) dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	verdict_t    verdict_q[$];
	int unsigned failures      = 0;
	int unsigned items_sent    = 0;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned hold_asked    = 0;
	int unsigned hold_taken    = 0;
	int unsigned hold_left     = 0;

	// decoder state mirror
	logic [7:0]  pend[3];
	int unsigned pend_n   = 0;
	int unsigned pt_cnt   = 0;
	int unsigned fffd_cnt = 0;
	int unsigned ctl_cnt  = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// receiver: random stalls, plus a long hold-off on request
	always @(negedge clk) begin
		if (hold_asked != hold_taken) begin
			hold_taken = hold_asked;
			hold_left  = HOLD_CYCLES;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	function automatic int unsigned seq_len(logic [7:0] c);
		if (c < 8'h80) return 1;
		if ((c & 8'hE0) == 8'hC0) return 2;
		if ((c & 8'hF0) == 8'hE0) return 3;
		if ((c & 8'hF8) == 8'hF0) return 4;
		return 1;
	endfunction

	function automatic int unsigned sat_up(int unsigned v);
		return (v >= CNT_MAX) ? CNT_MAX : v + 1;
	endfunction

	function automatic int unsigned single_point(logic [7:0] c);
		return (c < 8'h80) ? int'(c) : 0;
	endfunction

	function automatic int unsigned decode_seq(logic [7:0] s[4], int unsigned len);
		int unsigned cp;
		case (len)
			2: cp = 32'(s[0] & 8'h1F);
			3: cp = 32'(s[0] & 8'h0F);
			default: cp = 32'(s[0] & 8'h07);
		endcase
		for (int i = 1; i < len; i++)
			cp = (cp << 6) | 32'(s[i] & 8'h3F);
		return cp;
	endfunction

	task automatic tally(int unsigned cp);
		pt_cnt = sat_up(pt_cnt);
		if (cp == CP_REPLACEMENT)
			fffd_cnt = sat_up(fffd_cnt);
		else if (cp < CP_SPACE && cp != CP_TAB && cp != CP_LF && cp != CP_CR)
			ctl_cnt = sat_up(ctl_cnt);
	endtask

	task automatic take_byte(logic [7:0] b);
		logic [7:0]  s[4];
		int unsigned need;
		if (pend_n == 0) begin
			need = seq_len(b);
			if (need == 1) begin
				tally(single_point(b));
			end else begin
				pend[0] = b;
				pend_n  = 1;
			end
		end else begin
			need = seq_len(pend[0]);
			if (pend_n + 1 >= need) begin
				for (int i = 0; i < pend_n; i++)
					s[i] = pend[i];
				s[pend_n] = b;
				tally(decode_seq(s, need));
				pend_n = 0;
			end else begin
				pend[pend_n] = b;
				pend_n++;
			end
		end
	endtask

	// string ended mid-sequence: re-decode held bytes from the first one
	task automatic flush_pending();
		logic [7:0]  s[4];
		int unsigned i;
		int unsigned len;
		i = 0;
		while (i < pend_n) begin
			len = seq_len(pend[i]);
			if (len > 1 && i + len <= pend_n) begin
				for (int k = 0; k < len; k++)
					s[k] = pend[i + k];
				tally(decode_seq(s, len));
				i += len;
			end else begin
				tally(single_point(pend[i]));
				i++;
			end
		end
		pend_n = 0;
	endtask

	task automatic predict_item(logic [7:0] b, logic has_byte, logic is_last,
			logic [17:0] w, logic [17:0] h);
		verdict_t          v;
		longint unsigned   n;
		if (has_byte)
			take_byte(b);
		if (is_last) begin
			flush_pending();
			n = pt_cnt;
			if (n == 0)
				v.status = ST_NO_TEXT;
			else if (longint'(fffd_cnt) * 20 > n)
				v.status = ST_REPLACEMENTS;
			else if (longint'(ctl_cnt) * 10 > n)
				v.status = ST_CONTROL;
			else if (w != 0 && h != 0 && (n * 960 < w || n * 16 > w))
				v.status = ST_COUNT;
			else
				v.status = ST_TRUSTED;
			v.accept = (v.status == ST_TRUSTED);
			v.chars  = 16'(pt_cnt);
			v.repl   = 16'(fffd_cnt);
			v.ctrl   = 16'(ctl_cnt);
			verdict_q.push_back(v);
			pt_cnt   = 0;
			fffd_cnt = 0;
			ctl_cnt  = 0;
		end
	endtask

	task automatic cmp_field(string name, logic [15:0] exp, logic [15:0] act);
		if (act !== exp) begin
			$error("%s: expected %0d, got %0d", name, exp, act);
			failures++;
		end
	endtask

	task automatic check_verdict(logic [M_TDATA_W-1:0] d);
		verdict_t v;
		if (verdict_q.size() == 0) begin
			$error("result transaction with nothing expected: %h", d);
			failures++;
			return;
		end
		v = verdict_q.pop_front();
		cmp_field("accept", 16'(v.accept), 16'(d[M_ACCEPT_BIT]));
		cmp_field("status", 16'(v.status), 16'(d[M_STATUS_LSB +: M_STATUS_W]));
		cmp_field("char_count", v.chars, d[M_CHAR_LSB +: M_COUNT_W]);
		cmp_field("replacement_count", v.repl, d[M_REPL_LSB +: M_COUNT_W]);
		cmp_field("control_count", v.ctrl, d[M_CTRL_LSB +: M_COUNT_W]);
	endtask

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready)
			check_verdict(m_axis_tdata);
	end

	task automatic send_item(logic [7:0] b, logic has_byte, logic is_last,
			logic [17:0] w, logic [17:0] h);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {4'b0, h, w, b};
		s_axis_tuser  <= has_byte;
		s_axis_tlast  <= is_last;
		do @(posedge clk); while (!s_axis_tready);
		predict_item(b, has_byte, is_last, w, h);
		if (has_byte || is_last)
			items_sent++;
	endtask

	// tail_empty: close the string with a separate item that carries no byte
	task automatic send_text(text_q_t txt, bit tail_empty, logic [17:0] w,
			logic [17:0] h, int unsigned junk_pct);
		for (int k = 0; k < txt.size(); k++) begin
			if ($urandom_range(99) < junk_pct)
				send_item(8'($urandom), 1'b0, 1'b0, 18'($urandom), 18'($urandom));
			send_item(txt[k], 1'b1, !tail_empty && k == txt.size() - 1, w, h);
		end
		if (tail_empty || txt.size() == 0)
			send_item(8'($urandom), 1'b0, 1'b1, w, h);
	endtask

	task automatic wait_results_drained();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (verdict_q.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		// continuation bytes are not checked by the block, so sometimes send junk
		if ($urandom_range(99) < 5)
			return 8'($urandom);
		return 8'h80 | 8'($urandom_range(63));
	endfunction

	task automatic test_directed();
		text_q_t t;
		t = {};
		send_text(t, 1'b0, 0, 0, 0);
		t = '{8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC, 8'hF0, 8'h9F, 8'h98, 8'h80};
		send_text(t, 1'b0, 18'd100, 18'd100, 0);
		t = '{8'hEF, 8'hBF, 8'hBD};
		send_text(t, 1'b0, 0, 0, 0);
		t = '{8'h09, 8'h0A, 8'h0D, 8'h00};
		send_text(t, 1'b0, 0, 0, 0);
		// one code point in the widest box
		t = '{8'h41};
		send_text(t, 1'b0, BOX_MAX, 18'd1, 0);
		// stray bytes decode as zero
		t = '{8'h80, 8'hFF};
		send_text(t, 1'b0, 18'd1, BOX_MAX, 0);
		send_item(8'h5A, 1'b0, 1'b0, BOX_MAX, BOX_MAX);
		t = '{8'h7F};
		send_text(t, 1'b0, 18'd15, 18'd1, 0);
		// truncated four-byte lead, then a two-byte sequence that still fits
		t = '{8'hF0, 8'hC3, 8'hA9};
		send_text(t, 1'b1, 0, 0, 0);
		wait_results_drained();
	endtask

	task automatic random_string();
		text_q_t     txt;
		int unsigned pts;
		int unsigned npts;
		int unsigned r;
		logic [17:0] w;
		logic [17:0] h;
		pts = 0;
		r = $urandom_range(99);
		if (r < 5) begin
			npts = 0;
		end else if (r < 15) begin
			npts = $urandom_range(1, 16);
			repeat (npts) txt.push_back(8'($urandom));
			pts = npts;
		end else begin
			npts = $urandom_range(1, 24);
			repeat (npts) begin
				r = $urandom_range(99);
				if (r < 55) begin
					txt.push_back(8'($urandom_range(8'h20, 8'h7F)));
				end else if (r < 62) begin
					txt.push_back(8'($urandom_range(0, 8'h1F)));
				end else if (r < 65) begin
					txt.push_back(8'hEF);
					txt.push_back(8'hBF);
					txt.push_back(8'hBD);
				end else if (r < 77) begin
					txt.push_back(8'hC0 | 8'($urandom_range(31)));
					txt.push_back(cont_byte());
				end else if (r < 87) begin
					txt.push_back(8'hE0 | 8'($urandom_range(15)));
					repeat (2) txt.push_back(cont_byte());
				end else if (r < 95) begin
					txt.push_back(8'hF0 | 8'($urandom_range(7)));
					repeat (3) txt.push_back(cont_byte());
				end else if ($urandom_range(1)) begin
					txt.push_back(8'($urandom_range(8'h80, 8'hBF)));
				end else begin
					txt.push_back(8'($urandom_range(8'hF8, 8'hFF)));
				end
			end
			pts = npts;
			// leave a sequence unfinished at the end of the string
			if ($urandom_range(99) < 15) begin
				r = $urandom_range(2, 4);
				if (r == 2)
					txt.push_back(8'hC0 | 8'($urandom_range(31)));
				else if (r == 3)
					txt.push_back(8'hE0 | 8'($urandom_range(15)));
				else
					txt.push_back(8'hF0 | 8'($urandom_range(7)));
				repeat ($urandom_range(0, r - 2)) txt.push_back(cont_byte());
				pts++;
			end
		end
		case ($urandom_range(5))
			0: w = 0;
			1: w = 18'($urandom);
			2: w = 18'($urandom_range(16 * pts, (960 * pts > BOX_MAX) ? BOX_MAX : 960 * pts));
			3: w = (960 * pts + 1 > BOX_MAX) ? BOX_MAX : 18'(960 * pts + 1);
			4: w = (pts == 0) ? 18'd0 : 18'(16 * pts - 1);
			default: w = BOX_MAX;
		endcase
		r = $urandom_range(9);
		h = (r == 0) ? 18'd0 : (r == 1) ? BOX_MAX : 18'($urandom);
		send_text(txt, $urandom_range(99) < 30, w, h, 3);
	endtask

	task automatic test_random(int unsigned send_pct, int unsigned recv_pct,
			int unsigned n_items);
		int unsigned start;
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		start = items_sent;
		while (items_sent - start < n_items)
			random_string();
		wait_results_drained();
	endtask

	// receiver stops for a long while, so input stalls once the pipeline fills
	task automatic test_backpressure();
		text_q_t t;
		hold_asked++;
		t = '{8'h41, 8'h42};
		repeat (12) send_text(t, 1'b0, 18'd40, 18'd40, 0);
		wait_results_drained();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		send_idle_pct = 9;
		recv_idle_pct = 67;
		test_directed();
		test_random(9, 67, 200);
		test_random(67, 9, 200);
		test_random(0, 0, 200);
		test_backpressure();
		wait_results_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (failures == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
